[sv/fixed_to_decimal_ascii_macros.svh]
`ifndef FIXED_TO_DECIMAL_ASCII_MACROS_SVH
`define FIXED_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define FDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/fda_pkg.sv]
`default_nettype none
package fda_pkg;

    localparam int VAL_W  = 48;
    localparam int DEC_W  = 3;
    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] ASCII_POINT = 8'h2E;

    typedef struct packed {
        logic             neg;
        logic [VAL_W-1:0] mag;
        logic [DEC_W-1:0] dec;
    } t_job;

endpackage
`default_nettype wire

[sv/fda_front.sv]
`default_nettype none
module fda_front #(
    parameter int MAX_DECIMALS = 6
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire logic signed [fda_pkg::VAL_W-1:0] i_value,
    input  wire logic [fda_pkg::DEC_W-1:0]       i_decimals,
    output logic                                 o_full,
    output logic                                 o_job_valid,
    output fda_pkg::t_job                        o_job,
    input  wire logic                            i_job_ready
);
    import fda_pkg::*;

    logic r_valid, n_valid;
    t_job r_job;
    t_job n_job;
    logic accept;

    assign o_full      = r_valid & ~i_job_ready;
    assign accept      = i_push & ~o_full;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    // classify: sign, magnitude, clamp the decimal count
    always_comb begin
        n_job.neg = i_value[VAL_W-1];
        n_job.mag = i_value[VAL_W-1] ? (~i_value + 1'b1) : i_value;
        if ({1'b0, i_decimals} > 4'(MAX_DECIMALS)) begin
            n_job.dec = DEC_W'(MAX_DECIMALS);
        end else begin
            n_job.dec = i_decimals;
        end
        n_valid = accept | (r_valid & ~i_job_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule
`default_nettype wire

[sv/fda_fifo.sv]
`default_nettype none
module fda_fifo (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_wr_valid,
    input  fda_pkg::t_job i_wr_job,
    output logic         o_wr_ready,
    output logic         o_rd_valid,
    output fda_pkg::t_job o_rd_job,
    input  wire logic    i_rd_pop
);
    import fda_pkg::*;

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic       wr, rd;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_job   = r_mem[r_rd];
    assign wr         = i_wr_valid & o_wr_ready;
    assign rd         = i_rd_pop & o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (wr) begin
                r_wr <= ~r_wr;
            end
            if (rd) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, wr} - {1'b0, rd};
        end
        if (wr) begin
            r_mem[r_wr] <= i_wr_job;
        end
    end

endmodule
`default_nettype wire

[sv/fda_back.sv]
`default_nettype none
`include "fixed_to_decimal_ascii_macros.svh"
module fda_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_job_valid,
    input  fda_pkg::t_job                 i_job,
    output logic                          o_job_pop,
    output logic                          o_empty,
    output logic [fda_pkg::CHAR_W-1:0]    o_char_out,
    output logic                          o_last_char,
    input  wire logic                     i_pop
);
    import fda_pkg::*;

    localparam int IP_W   = VAL_W - FRAC_BITS;
    localparam int NDIG   = (IP_W * 30103) / 100000 + 1;
    localparam int DIDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int CNT_W  = $clog2(IP_W);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CONV  = 6'b000010,
        S_SIGN  = 6'b000100,
        S_INT   = 6'b001000,
        S_POINT = 6'b010000,
        S_FRAC  = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic                       r_neg, n_neg;
    logic [DEC_W-1:0]           r_dec, n_dec;
    logic [DEC_W-1:0]           r_fcnt, n_fcnt;
    logic [FRAC_BITS-1:0]       r_frac, n_frac;
    logic [IP_W-1:0]            r_bin, n_bin;
    logic [NDIG-1:0][3:0]       r_bcd, n_bcd;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [DIDX_W-1:0]          r_didx, n_didx;
    logic                       r_seen, n_seen;
    logic                       r_out_valid;
    logic [CHAR_W-1:0]          r_out_char;
    logic                       r_out_last;

    logic [NDIG-1:0][3:0]       adj;
    logic [FRAC_BITS+3:0]       prod;
    logic [3:0]                 cur;
    logic                       out_ready, load, load_last, show, step;
    logic [CHAR_W-1:0]          load_char;

    assign o_empty     = ~r_out_valid;
    assign o_char_out  = r_out_char;
    assign o_last_char = r_out_last;
    assign out_ready   = ~r_out_valid | i_pop;
    assign cur         = r_bcd[r_didx];
    assign prod        = ({4'b0, r_frac} << 3) + ({4'b0, r_frac} << 1);
    assign show        = (cur != 4'd0) | r_seen | (r_didx == '0);
    assign step        = show ? out_ready : 1'b1;

    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_neg     = r_neg;
        n_dec     = r_dec;
        n_fcnt    = r_fcnt;
        n_frac    = r_frac;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_didx    = r_didx;
        n_seen    = r_seen;
        o_job_pop = 1'b0;
        load      = 1'b0;
        load_last = 1'b0;
        load_char = ASCII_ZERO;
        unique case (r_state)
            S_IDLE: begin
                o_job_pop = i_job_valid;
                if (i_job_valid) begin
                    n_neg   = i_job.neg;
                    n_dec   = i_job.dec;
                    n_frac  = i_job.mag[FRAC_BITS-1:0];
                    n_bin   = i_job.mag[VAL_W-1:FRAC_BITS];
                    n_bcd   = '0;
                    n_cnt   = CNT_W'(IP_W - 1);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = (4*NDIG)'({adj, r_bin[IP_W-1]});
                n_bin = {r_bin[IP_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_didx  = DIDX_W'(NDIG - 1);
                    n_seen  = 1'b0;
                    n_state = r_neg ? S_SIGN : S_INT;
                end
            end
            S_SIGN: begin
                if (out_ready) begin
                    load      = 1'b1;
                    load_char = ASCII_MINUS;
                    n_state   = S_INT;
                end
            end
            S_INT: begin
                if (show && out_ready) begin
                    load      = 1'b1;
                    load_char = ASCII_ZERO + {4'b0, cur};
                    load_last = (r_didx == '0) && (r_dec == '0);
                    n_seen    = 1'b1;
                end
                if (step) begin
                    if (r_didx == '0) begin
                        n_state = (r_dec != '0) ? S_POINT : S_IDLE;
                    end else begin
                        n_didx = r_didx - 1'b1;
                    end
                end
            end
            S_POINT: begin
                if (out_ready) begin
                    load      = 1'b1;
                    load_char = ASCII_POINT;
                    n_fcnt    = r_dec;
                    n_state   = S_FRAC;
                end
            end
            S_FRAC: begin
                if (out_ready) begin
                    load      = 1'b1;
                    load_char = ASCII_ZERO + {4'b0, prod[FRAC_BITS+3:FRAC_BITS]};
                    load_last = (r_fcnt == DEC_W'(1));
                    n_frac    = prod[FRAC_BITS-1:0];
                    n_fcnt    = r_fcnt - 1'b1;
                    if (r_fcnt == DEC_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
        r_neg  <= n_neg;
        r_dec  <= n_dec;
        r_fcnt <= n_fcnt;
        r_frac <= n_frac;
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_didx <= n_didx;
        r_seen <= n_seen;
        if (load) begin
            r_out_char <= load_char;
            r_out_last <= load_last;
        end
    end

    `FDA_ASSERT_NOW(a_conv_silent, r_state == S_CONV, !load, "output loaded during conversion")
    `FDA_ASSERT_NOW(a_frac_count, r_state == S_FRAC, r_fcnt != '0, "fraction state with zero count")
    `FDA_ASSERT_NEXT(a_last_idle, load && load_last, r_state == S_IDLE, "last character not ending the item")
    `FDA_ASSERT_NOW(a_point_dec, r_state == S_POINT, r_dec != '0, "point emitted with no decimals")

endmodule
`default_nettype wire

[sv/fixed_to_decimal_ascii.sv]
// Fixed-point to ASCII decimal text converter.
// Input queue side: drive i_value (signed, FRAC_BITS fraction bits) and
// i_decimals, raise push; the item is taken on a clock edge with push high
// and full low. Output queue side: while empty is low, o_char_out holds the
// next character and o_last_char marks the end of one number's text; raise
// pop to take it. Text is an optional '-', the integer digits without
// leading zeros, then, for a nonzero decimal count, '.' and up to
// MAX_DECIMALS truncated fraction digits. A front register and a two-entry
// queue hold up to three items ahead of the converter; full rises only once
// all three are waiting. Per item the converter fetches the item while idle,
// runs a shift-and-add-3 binary to BCD loop over the 48 - FRAC_BITS integer
// bits, then emits the sign if any, steps through every integer digit
// position (leading zeros included, not emitted) and emits the point and
// fraction digits. If pop stays low, the converter stops at the next
// character to emit (the BCD loop and the skipping of leading zeros go on),
// with the waiting character in the output register; nothing is dropped.
// Synchronous reset empties the queue and output register and returns the
// converter to idle.
`default_nettype none
module fixed_to_decimal_ascii #(
    parameter int FRAC_BITS    = 16,
    parameter int MAX_DECIMALS = 6
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic signed [fda_pkg::VAL_W-1:0] i_value,
    input  wire logic [fda_pkg::DEC_W-1:0]        i_decimals,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [fda_pkg::CHAR_W-1:0]            o_char_out,
    output logic                                  o_last_char
);
    import fda_pkg::*;

    logic f_valid, f_ready;
    t_job f_job;
    logic q_valid, q_pop;
    t_job q_job;

    fda_front #(
        .MAX_DECIMALS(MAX_DECIMALS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_value    (i_value),
        .i_decimals (i_decimals),
        .o_full     (full),
        .o_job_valid(f_valid),
        .o_job      (f_job),
        .i_job_ready(f_ready)
    );

    fda_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_valid(f_valid),
        .i_wr_job  (f_job),
        .o_wr_ready(f_ready),
        .o_rd_valid(q_valid),
        .o_rd_job  (q_job),
        .i_rd_pop  (q_pop)
    );

    fda_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(q_valid),
        .i_job      (q_job),
        .o_job_pop  (q_pop),
        .o_empty    (empty),
        .o_char_out (o_char_out),
        .o_last_char(o_last_char),
        .i_pop      (pop)
    );

endmodule
`default_nettype wire

[tb/tb_fixed_to_decimal_ascii.sv]
`timescale 1ns / 1ps

module tb_fixed_to_decimal_ascii;
    import fda_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_DECIMALS = 6;
    localparam int N_RANDOM     = 308;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic [DEC_W-1:0] decimals;
    } t_num_item;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
    } t_text_char;

    typedef enum logic [1:0] {POP_ALWAYS, POP_HALF, POP_RARE, POP_OFF} t_stall_mode;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    logic signed [VAL_W-1:0] i_value = '0;
    logic [DEC_W-1:0]        i_decimals = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [CHAR_W-1:0]       o_char_out;
    logic                    o_last_char;

    t_num_item   pending_q[$];
    t_text_char  exp_text_q[$];
    t_text_char  want_char;
    int          err_cnt = 0;
    int          chars_seen = 0;
    int          cycle_cnt = 0;
    logic        item_taken = 1'b0;
    int          burst_left = 4;
    int          gap_left = 0;
    t_stall_mode stall_mode = POP_ALWAYS;
    int          stall_phase_left = 40;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    fixed_to_decimal_ascii #(
        .FRAC_BITS   (FRAC_BITS),
        .MAX_DECIMALS(MAX_DECIMALS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_value    (i_value),
        .i_decimals (i_decimals),
        .empty      (empty),
        .pop        (pop),
        .o_char_out (o_char_out),
        .o_last_char(o_last_char)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [VAL_W-1:0] make_fixed(bit neg, logic [31:0] ip,
                                                    logic [FRAC_BITS-1:0] frac);
        logic [VAL_W-1:0] m;
        m = {ip, frac};
        return neg ? -m : m;
    endfunction

    // Expected text of one number: sign, integer digits, point, truncated fraction.
    function automatic void spell_decimal(logic [VAL_W-1:0] raw, logic [DEC_W-1:0] dec_in);
        logic             neg;
        logic [63:0]      mag;
        logic [63:0]      ip;
        logic [63:0]      frac;
        int unsigned      ndec;
        logic [3:0]       digits[$];
        neg  = raw[VAL_W-1];
        mag  = neg ? {16'd0, (~raw) + 48'd1} : {16'd0, raw};
        ndec = (dec_in > MAX_DECIMALS) ? MAX_DECIMALS : dec_in;
        ip   = mag >> FRAC_BITS;
        frac = mag & ((64'd1 << FRAC_BITS) - 1);
        if (neg) begin
            exp_text_q.push_back('{ASCII_MINUS, 1'b0});
        end
        do begin
            digits.push_front(4'(ip % 10));
            ip = ip / 10;
        end while (ip != 0);
        foreach (digits[i]) begin
            exp_text_q.push_back('{ASCII_ZERO + 8'(digits[i]), 1'b0});
        end
        if (ndec > 0) begin
            exp_text_q.push_back('{ASCII_POINT, 1'b0});
            for (int i = 0; i < ndec; i++) begin
                frac = frac * 10;
                exp_text_q.push_back('{ASCII_ZERO + 8'(frac >> FRAC_BITS), 1'b0});
                frac = frac & ((64'd1 << FRAC_BITS) - 1);
            end
        end
        exp_text_q[exp_text_q.size()-1].is_last = 1'b1;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        logic [31:0] ip;
        logic [31:0] p10;
        int unsigned k;
        bit          neg;
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VAL_W'({$urandom(), $urandom()});
            4: return make_fixed(neg, $urandom_range(0, 20), FRAC_BITS'($urandom()));
            5: begin
                k   = $urandom_range(0, 9);
                p10 = 1;
                repeat (k) p10 = p10 * 10;
                ip  = p10 - $urandom_range(0, 1);
                return make_fixed(neg, ip,
                                  $urandom_range(0, 1) ? '0 : FRAC_BITS'($urandom()));
            end
            6: return -{32'd0, 16'($urandom_range(1, 16'hFFFF))};
            7: begin
                case ($urandom_range(0, 3))
                    0: return 48'h7FFF_FFFF_FFFF;
                    1: return 48'h8000_0000_0000;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return make_fixed(neg, $urandom_range(0, 99999),
                                       FRAC_BITS'($urandom()));
        endcase
    endfunction

    // Sender: bursts of items with random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (item_taken) begin
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = $urandom_range(0, 3) == 0 ? $urandom_range(10, 60)
                                                           : $urandom_range(0, 3);
                end
            end
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                push <= 1'b0;
            end else if (pending_q.size() > 0) begin
                push       <= 1'b1;
                i_value    <= pending_q[0].value;
                i_decimals <= pending_q[0].decimals;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: stall modes in phases, plus one long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (stall_phase_left == 0) begin
                stall_mode       = t_stall_mode'($urandom_range(0, 3));
                stall_phase_left = $urandom_range(16, 128);
            end else begin
                stall_phase_left = stall_phase_left - 1;
            end
            if (!hold_done && chars_seen >= 300) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end else begin
                case (stall_mode)
                    POP_ALWAYS: pop <= 1'b1;
                    POP_HALF:   pop <= 1'($urandom_range(0, 1));
                    POP_RARE:   pop <= ($urandom_range(0, 7) == 0);
                    default:    pop <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        item_taken = 1'b0;
        if (i_rst_n) begin
            if (pop && !empty) begin
                chars_seen = chars_seen + 1;
                if (exp_text_q.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    $display("%0t: unexpected char, expected none, got %h last %b",
                             $time, o_char_out, o_last_char);
                end else begin
                    want_char = exp_text_q.pop_front();
                    if (o_char_out !== want_char.ch) begin
                        err_cnt = err_cnt + 1;
                        $display("%0t: char mismatch, expected %h, got %h",
                                 $time, want_char.ch, o_char_out);
                    end
                    if (o_last_char !== want_char.is_last) begin
                        err_cnt = err_cnt + 1;
                        $display("%0t: last flag mismatch, expected %b, got %b",
                                 $time, want_char.is_last, o_last_char);
                    end
                end
            end
            if (push && !full) begin
                item_taken = 1'b1;
                spell_decimal(i_value, i_decimals);
                void'(pending_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        pending_q.push_back('{make_fixed(0, 0, 0), 3'd0});
        pending_q.push_back('{make_fixed(0, 0, 0), 3'd6});
        pending_q.push_back('{48'h7FFF_FFFF_FFFF, 3'd6});
        pending_q.push_back('{48'h8000_0000_0000, 3'd6});
        pending_q.push_back('{48'h8000_0000_0000, 3'd0});
        pending_q.push_back('{48'hFFFF_FFFF_FFFF, 3'd0});
        pending_q.push_back('{48'hFFFF_FFFF_FFFF, 3'd6});
        pending_q.push_back('{make_fixed(1, 0, 16'h4000), 3'd0});
        pending_q.push_back('{make_fixed(0, 10, 0), 3'd0});
        pending_q.push_back('{make_fixed(0, 100, 0), 3'd1});
        pending_q.push_back('{make_fixed(0, 9, 0), 3'd0});
        pending_q.push_back('{make_fixed(0, 99, 16'hFFFF), 3'd6});
        pending_q.push_back('{make_fixed(0, 1000000000, 0), 3'd2});
        pending_q.push_back('{make_fixed(1, 999999999, 16'h8000), 3'd3});
        pending_q.push_back('{make_fixed(0, 1, 16'h8000), 3'd7});
        pending_q.push_back('{make_fixed(1, 12345, 16'h1999), 3'd5});
        pending_q.push_back('{make_fixed(1, 10000, 0), 3'd0});
        pending_q.push_back('{make_fixed(0, 0, 16'h0001), 3'd6});
        pending_q.push_back('{make_fixed(0, 42, 16'hAAAA), 3'd2});
        pending_q.push_back('{make_fixed(0, 42, 16'hAAAA), 3'd3});
        pending_q.push_back('{make_fixed(0, 42, 16'hAAAA), 3'd4});
        pending_q.push_back('{make_fixed(1, 1000, 16'h0001), 3'd7});
        for (int i = 0; i < N_RANDOM; i++) begin
            pending_q.push_back('{rand_value(), 3'($urandom_range(0, 7))});
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || exp_text_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
